/* sv/mlcd_pkg.sv */
// ----------------------------------------------------------------------------
// mlcd_pkg - shared types and constants of the camera direction core
// Command and status words of the serial arithmetic unit, the fixed pi
// constant and the Taylor series divisor tables.
// ----------------------------------------------------------------------------
package mlcd_pkg;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [63:0] a;      // multiplicand, or dividend aligned to bit 63
      logic [63:0] b;      // multiplier, or divisor in the low 32 bits
      logic [6:0]  count;  // number of serial steps
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;      // product or quotient
      logic [31:0] rem;    // remainder of a division
   } alu_rsp_type;

   localparam logic [63:0] PI_Q32  = 64'h0000_0003_243F_6A88;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // sine term n: divide by (2n)(2n+1)
   function automatic logic [8:0] sin_div(input logic [2:0] idx);
      logic [8:0] d;
      case (idx)
         3'd0:    d = 9'd6;
         3'd1:    d = 9'd20;
         3'd2:    d = 9'd42;
         3'd3:    d = 9'd72;
         3'd4:    d = 9'd110;
         3'd5:    d = 9'd156;
         3'd6:    d = 9'd210;
         3'd7:    d = 9'd272;
         default: d = 9'd6;
      endcase
      return d;
   endfunction

   // cosine term n: divide by (2n-1)(2n)
   function automatic logic [8:0] cos_div(input logic [2:0] idx);
      logic [8:0] d;
      case (idx)
         3'd0:    d = 9'd2;
         3'd1:    d = 9'd12;
         3'd2:    d = 9'd30;
         3'd3:    d = 9'd56;
         3'd4:    d = 9'd90;
         3'd5:    d = 9'd132;
         3'd6:    d = 9'd182;
         3'd7:    d = 9'd240;
         default: d = 9'd2;
      endcase
      return d;
   endfunction

endpackage

/* sv/mouse_look_camera_direction_core.sv */
// ----------------------------------------------------------------------------
// mouse_look_camera_direction_core - pointer motion to yaw, pitch and view
// direction
// Each req word carries a pointer position. The motion since the previous
// position, scaled by the panning speed, moves yaw (wrapped to 0..360 deg)
// and pitch (clamped to +-89 deg). Each req word yields one rsp word with
// both angles and the unit direction vector in Q1.DIR_FRAC_BITS.
//
// Channels: req_* carries x/y, rsp_* the result, csr_* writes the panning
// speed (always ready, write only while no word is in flight).
// Throughput: one word at a time. Time is set by the single bit-serial
// multiply/divide unit: every product takes one multiplier bit per cycle and
// every quotient one dividend bit per cycle; two 9-term sine/cosine series
// dominate.
// A finished rsp word sits in an output register, so the next req word is
// taken while the receiver stalls; the core holds before its own result
// write until that register is free.
// Reset: first position gives zero motion, angles zero, speed 26 (0.1 deg/px).
// ----------------------------------------------------------------------------
module mouse_look_camera_direction_core #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int DIR_FRAC_BITS   = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_pos[15:0], y_pos[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // yaw_angle[16:0], pitch_angle[32:17],
                                    // dir_x[48:33], dir_y[64:49],
                                    // dir_z[80:65], zero[87:81]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata    // panning_speed
);

   localparam int AF      = ANGLE_FRAC_BITS;
   localparam int DF      = DIR_FRAC_BITS;
   localparam int YAW_W   = $clog2(360 * (2 ** AF));
   localparam int PITCH_W = $clog2(89 * (2 ** AF)) + 1;
   localparam int SH_L    = (AF >= 8) ? AF - 8 : 0;
   localparam int SH_R    = (AF >= 8) ? 0 : 8 - AF;
   localparam logic [31:0] DEG360 = 32'(360 * (2 ** AF));
   localparam logic [31:0] DEG270 = 32'(270 * (2 ** AF));
   localparam logic [31:0] DEG180 = 32'(180 * (2 ** AF));
   localparam logic [31:0] DEG90  = 32'(90 * (2 ** AF));
   localparam logic [31:0] DEG45  = 32'(45 * (2 ** AF));
   localparam logic signed [47:0] P89 = 48'(89 * (2 ** AF));
   localparam logic [63:0] XRND = 64'(1) << (AF + 1);

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_YMUL   = 15'b000000000000010,
      S_YMOD   = 15'b000000000000100,
      S_PMUL   = 15'b000000000001000,
      S_REDUCE = 15'b000000000010000,
      S_XMUL   = 15'b000000000100000,
      S_XDIV   = 15'b000000001000000,
      S_X2MUL  = 15'b000000010000000,
      S_TSMUL  = 15'b000000100000000,
      S_TSDIV  = 15'b000001000000000,
      S_TCMUL  = 15'b000010000000000,
      S_TCDIV  = 15'b000100000000000,
      S_DXMUL  = 15'b001000000000000,
      S_DZMUL  = 15'b010000000000000,
      S_WRITE  = 15'b100000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  first_ff, first_in;
   logic [15:0]           prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [16:0]           dy_mag_ff, dy_mag_in;
   logic                  dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic [15:0]           speed_ff, speed_in;
   logic [YAW_W-1:0]      yaw_acc_ff, yaw_acc_in;
   logic signed [PITCH_W-1:0] pitch_acc_ff, pitch_acc_in;
   logic                  tneg_ff, tneg_in;
   logic                  sel_pitch_ff, sel_pitch_in;
   logic [1:0]            quad_ff, quad_in;
   logic                  swp_ff, swp_in;
   logic [30:0]           x2_ff, x2_in, ts_ff, ts_in, tc_ff, tc_in;
   logic signed [33:0]    s_acc_ff, s_acc_in, c_acc_ff, c_acc_in;
   logic [2:0]            idx_ff, idx_in;
   logic [30:0]           ys_ff, ys_in, yc_ff, yc_in, ps_ff, ps_in, pc_ff, pc_in;
   logic                  ysn_ff, ysn_in, ycn_ff, ycn_in, psn_ff, psn_in;
   logic [15:0]           dirx_ff, dirx_in, dirz_ff, dirz_in;
   mlcd_pkg::alu_cmd_type cmd_ff, cmd_in;
   mlcd_pkg::alu_rsp_type alu_rsp;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [87:0]           rsp_data_ff, rsp_data_in;

   logic signed [16:0]    dx_w, dy_w;
   logic [16:0]           dxm_w, dym_w;
   logic [47:0]           scaled_w, abs_w;
   logic signed [47:0]    delta_w, sum_w, pclamp_w;
   logic [31:0]           yaw_new_w;
   logic [PITCH_W-1:0]    pabs_w;
   logic [31:0]           ang_w, r_w, deg_w;
   logic [1:0]            quad_w;
   logic                  swp_w;
   logic [63:0]           xr_w;
   logic [30:0]           x_w;
   logic signed [33:0]    s_new_w, c_new_w;
   logic [30:0]           s_mag_w, c_mag_w, s_fin_w, c_fin_w;
   logic                  fswap_w;
   logic [15:0]           diry_w;

   function automatic mlcd_pkg::alu_cmd_type mk_cmd(input mlcd_pkg::alu_op_type op,
                                                    input logic [63:0] a,
                                                    input logic [63:0] b,
                                                    input logic [6:0] count);
      mlcd_pkg::alu_cmd_type c;
      c.start = 1'b1;
      c.op    = op;
      c.a     = a;
      c.b     = b;
      c.count = count;
      return c;
   endfunction

   // shift right by s with round half up; s may be zero
   function automatic logic [63:0] rnd_shift(input logic [63:0] v, input int s);
      return ((v << 1) + (64'(1) << s)) >> (s + 1);
   endfunction

   function automatic logic [15:0] sgn16(input logic [63:0] mag, input logic neg);
      logic [63:0] v;
      v = neg ? -mag : mag;
      return v[15:0];
   endfunction

   mlcd_serial_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .rsp   (alu_rsp)
   );

   // datapath terms shared by several states
   always_comb begin
      dx_w  = first_ff ? 17'sd0
                       : $signed({req_tdata[15], req_tdata[15:0]})
                         - $signed({prev_x_ff[15], prev_x_ff});
      dy_w  = first_ff ? 17'sd0
                       : $signed({prev_y_ff[15], prev_y_ff})
                         - $signed({req_tdata[31], req_tdata[31:16]});
      dxm_w = dx_w[16] ? 17'(-dx_w) : 17'(dx_w);
      dym_w = dy_w[16] ? 17'(-dy_w) : 17'(dy_w);

      scaled_w = (48'(alu_rsp.q[33:0]) << SH_L) >> SH_R;
      if (((state_ff == S_PMUL) ? dy_neg_ff : dx_neg_ff)) begin
         delta_w = -$signed(scaled_w);
      end else begin
         delta_w = $signed(scaled_w);
      end
      if (state_ff == S_PMUL) begin
         sum_w = 48'(pitch_acc_ff) + delta_w;
      end else begin
         sum_w = $signed(48'(yaw_acc_ff)) + delta_w;
      end
      abs_w = sum_w[47] ? 48'(-sum_w) : 48'(sum_w);
      yaw_new_w = (tneg_ff && (alu_rsp.rem != 32'd0)) ? DEG360 - alu_rsp.rem
                                                       : alu_rsp.rem;
      if (sum_w > P89) begin
         pclamp_w = P89;
      end else if (sum_w < -P89) begin
         pclamp_w = -P89;
      end else begin
         pclamp_w = sum_w;
      end

      // quadrant reduction of the angle in work
      pabs_w = pitch_acc_ff[PITCH_W-1] ? PITCH_W'(-pitch_acc_ff) : PITCH_W'(pitch_acc_ff);
      ang_w  = sel_pitch_ff ? 32'(pabs_w) : 32'(yaw_acc_ff);
      if (ang_w >= DEG270) begin
         quad_w = 2'd3;
         r_w    = ang_w - DEG270;
      end else if (ang_w >= DEG180) begin
         quad_w = 2'd2;
         r_w    = ang_w - DEG180;
      end else if (ang_w >= DEG90) begin
         quad_w = 2'd1;
         r_w    = ang_w - DEG90;
      end else begin
         quad_w = 2'd0;
         r_w    = ang_w;
      end
      swp_w = (r_w > DEG45);
      deg_w = swp_w ? DEG90 - r_w : r_w;

      xr_w = (alu_rsp.q + XRND) >> (AF + 2);
      x_w  = xr_w[30:0];

      // odd terms subtract, even terms add
      if (idx_ff[0]) begin
         s_new_w = s_acc_ff + $signed(34'(alu_rsp.q[30:0]));
         c_new_w = c_acc_ff + $signed(34'(alu_rsp.q[30:0]));
      end else begin
         s_new_w = s_acc_ff - $signed(34'(alu_rsp.q[30:0]));
         c_new_w = c_acc_ff - $signed(34'(alu_rsp.q[30:0]));
      end
      s_mag_w = s_acc_ff[33] ? 31'd0 : s_acc_ff[30:0];
      c_mag_w = c_new_w[33] ? 31'd0 : c_new_w[30:0];
      fswap_w = swp_ff ^ quad_ff[0];
      s_fin_w = fswap_w ? c_mag_w : s_mag_w;
      c_fin_w = fswap_w ? s_mag_w : c_mag_w;

      diry_w = sgn16(rnd_shift(64'(ps_ff), 30 - DF), psn_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      dy_mag_in    = dy_mag_ff;
      dx_neg_in    = dx_neg_ff;
      dy_neg_in    = dy_neg_ff;
      speed_in     = (csr_valid) ? csr_wdata : speed_ff;
      yaw_acc_in   = yaw_acc_ff;
      pitch_acc_in = pitch_acc_ff;
      tneg_in      = tneg_ff;
      sel_pitch_in = sel_pitch_ff;
      quad_in      = quad_ff;
      swp_in       = swp_ff;
      x2_in        = x2_ff;
      ts_in        = ts_ff;
      tc_in        = tc_ff;
      s_acc_in     = s_acc_ff;
      c_acc_in     = c_acc_ff;
      idx_in       = idx_ff;
      ys_in        = ys_ff;
      yc_in        = yc_ff;
      ps_in        = ps_ff;
      pc_in        = pc_ff;
      ysn_in       = ysn_ff;
      ycn_in       = ycn_ff;
      psn_in       = psn_ff;
      dirx_in      = dirx_ff;
      dirz_in      = dirz_ff;
      cmd_in       = cmd_ff;
      cmd_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               first_in  = 1'b0;
               prev_x_in = req_tdata[15:0];
               prev_y_in = req_tdata[31:16];
               dx_neg_in = dx_w[16];
               dy_mag_in = dym_w;
               dy_neg_in = dy_w[16];
               cmd_in    = mk_cmd(mlcd_pkg::ALU_MUL, 64'(dxm_w), 64'(speed_ff), 7'd16);
               state_in  = S_YMUL;
            end
         end
         S_YMUL: begin
            if (alu_rsp.done) begin
               tneg_in  = sum_w[47];
               cmd_in   = mk_cmd(mlcd_pkg::ALU_DIV, {abs_w, 16'd0}, 64'(DEG360), 7'd48);
               state_in = S_YMOD;
            end
         end
         S_YMOD: begin
            if (alu_rsp.done) begin
               yaw_acc_in = YAW_W'(yaw_new_w);
               cmd_in     = mk_cmd(mlcd_pkg::ALU_MUL, 64'(dy_mag_ff), 64'(speed_ff), 7'd16);
               state_in   = S_PMUL;
            end
         end
         S_PMUL: begin
            if (alu_rsp.done) begin
               pitch_acc_in = PITCH_W'(pclamp_w);
               sel_pitch_in = 1'b0;
               state_in     = S_REDUCE;
            end
         end
         S_REDUCE: begin
            quad_in  = quad_w;
            swp_in   = swp_w;
            cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, mlcd_pkg::PI_Q32, 64'(deg_w), 7'(YAW_W));
            state_in = S_XMUL;
         end
         S_XMUL: begin
            if (alu_rsp.done) begin
               cmd_in   = mk_cmd(mlcd_pkg::ALU_DIV, alu_rsp.q, 64'd180, 7'd64);
               state_in = S_XDIV;
            end
         end
         S_XDIV: begin
            if (alu_rsp.done) begin
               ts_in    = x_w;
               s_acc_in = $signed(34'(x_w));
               tc_in    = mlcd_pkg::Q30_ONE;
               c_acc_in = $signed(34'(mlcd_pkg::Q30_ONE));
               idx_in   = 3'd0;
               cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(x_w), 64'(x_w), 7'd31);
               state_in = S_X2MUL;
            end
         end
         S_X2MUL: begin
            if (alu_rsp.done) begin
               x2_in    = alu_rsp.q[60:30];
               cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(ts_ff), 64'(alu_rsp.q[60:30]),
                                 7'd31);
               state_in = S_TSMUL;
            end
         end
         S_TSMUL: begin
            if (alu_rsp.done) begin
               cmd_in   = mk_cmd(mlcd_pkg::ALU_DIV, {alu_rsp.q[61:30], 32'd0},
                                 64'(mlcd_pkg::sin_div(idx_ff)), 7'd32);
               state_in = S_TSDIV;
            end
         end
         S_TSDIV: begin
            if (alu_rsp.done) begin
               ts_in    = alu_rsp.q[30:0];
               s_acc_in = s_new_w;
               cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(tc_ff), 64'(x2_ff), 7'd31);
               state_in = S_TCMUL;
            end
         end
         S_TCMUL: begin
            if (alu_rsp.done) begin
               cmd_in   = mk_cmd(mlcd_pkg::ALU_DIV, {alu_rsp.q[61:30], 32'd0},
                                 64'(mlcd_pkg::cos_div(idx_ff)), 7'd32);
               state_in = S_TCDIV;
            end
         end
         S_TCDIV: begin
            if (alu_rsp.done) begin
               tc_in    = alu_rsp.q[30:0];
               c_acc_in = c_new_w;
               if (idx_ff == 3'd7) begin
                  if (!sel_pitch_ff) begin
                     ys_in        = s_fin_w;
                     yc_in        = c_fin_w;
                     ysn_in       = quad_ff[1];
                     ycn_in       = quad_ff[0] ^ quad_ff[1];
                     sel_pitch_in = 1'b1;
                     state_in     = S_REDUCE;
                  end else begin
                     ps_in    = s_fin_w;
                     pc_in    = c_fin_w;
                     psn_in   = pitch_acc_ff[PITCH_W-1];
                     cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(yc_ff), 64'(c_fin_w), 7'd31);
                     state_in = S_DXMUL;
                  end
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(ts_ff), 64'(x2_ff), 7'd31);
                  state_in = S_TSMUL;
               end
            end
         end
         S_DXMUL: begin
            if (alu_rsp.done) begin
               dirx_in  = sgn16(rnd_shift(alu_rsp.q, 60 - DF), ycn_ff);
               cmd_in   = mk_cmd(mlcd_pkg::ALU_MUL, 64'(ys_ff), 64'(pc_ff), 7'd31);
               state_in = S_DZMUL;
            end
         end
         S_DZMUL: begin
            if (alu_rsp.done) begin
               dirz_in  = sgn16(rnd_shift(alu_rsp.q, 60 - DF), ysn_ff);
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {7'd0, dirz_ff, diry_w, dirx_ff, 16'(pitch_acc_ff),
                               17'(yaw_acc_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b1;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         speed_ff     <= 16'd26;
         yaw_acc_ff   <= '0;
         pitch_acc_ff <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         speed_ff     <= speed_in;
         yaw_acc_ff   <= yaw_acc_in;
         pitch_acc_ff <= pitch_acc_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dy_mag_ff    <= dy_mag_in;
      dx_neg_ff    <= dx_neg_in;
      dy_neg_ff    <= dy_neg_in;
      tneg_ff      <= tneg_in;
      sel_pitch_ff <= sel_pitch_in;
      quad_ff      <= quad_in;
      swp_ff       <= swp_in;
      x2_ff        <= x2_in;
      ts_ff        <= ts_in;
      tc_ff        <= tc_in;
      s_acc_ff     <= s_acc_in;
      c_acc_ff     <= c_acc_in;
      idx_ff       <= idx_in;
      ys_ff        <= ys_in;
      yc_ff        <= yc_in;
      ps_ff        <= ps_in;
      pc_ff        <= pc_in;
      ysn_ff       <= ysn_in;
      ycn_ff       <= ycn_in;
      psn_ff       <= psn_in;
      dirx_ff      <= dirx_in;
      dirz_ff      <= dirz_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

/* sv/mlcd_serial_alu.sv */
// ----------------------------------------------------------------------------
// mlcd_serial_alu - bit-serial multiply and divide unit
// Multiply consumes one multiplier bit per cycle (shift and add); divide
// produces one quotient bit per cycle (restoring, dividend from bit 63 down).
// ----------------------------------------------------------------------------
module mlcd_serial_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  mlcd_pkg::alu_cmd_type cmd,
   output mlcd_pkg::alu_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   mlcd_pkg::alu_op_type op_ff, op_in;
   logic [63:0]          a_ff, a_in;
   logic [63:0]          b_ff, b_in;
   logic [63:0]          acc_ff, acc_in;
   logic [31:0]          rem_ff, rem_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic [32:0]          rem_sh;
   logic [32:0]          rem_sub;
   logic                 fits;

   always_comb begin
      rem_sh  = {rem_ff, a_ff[63]};
      rem_sub = rem_sh - {1'b0, b_ff[31:0]};
      fits    = (rem_sh >= {1'b0, b_ff[31:0]});
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         a_in    = cmd.a;
         b_in    = cmd.b;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = cmd.count;
      end else if (busy_ff) begin
         if (op_ff == mlcd_pkg::ALU_MUL) begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[62:0], 1'b0};
            b_in = {1'b0, b_ff[63:1]};
         end else begin
            rem_in = fits ? rem_sub[31:0] : rem_sh[31:0];
            a_in   = {a_ff[62:0], fits};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = (op_ff == mlcd_pkg::ALU_MUL) ? acc_ff : a_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* sv/mlcd_checker.sv */
// ----------------------------------------------------------------------------
// mlcd_checker - port-level checks of the camera direction core
// Watches the req and rsp channels over time; attached by bind.
// ----------------------------------------------------------------------------
module mlcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   // one word in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a new result is written only while the core is busy with a word
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp word appeared while the core was idle");

endmodule

bind mouse_look_camera_direction_core mlcd_checker u_mlcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/mouse_look_camera_direction_core_tb.sv */
// ----------------------------------------------------------------------------
// mouse_look_camera_direction_core_tb - self-checking bench of the camera core
// Drives pointer positions, predicts yaw, pitch and the direction vector with
// a local fixed-point model and compares every rsp word field by field.
// Runs several panning speeds, extremes included, under random flow control.
// ----------------------------------------------------------------------------
module mouse_look_camera_direction_core_tb;

   localparam int AFB = 8;
   localparam int DFB = 14;
   localparam longint DEG90  = 64'sd90 <<< AFB;
   localparam longint DEG45  = 64'sd45 <<< AFB;
   localparam longint DEG89  = 64'sd89 <<< AFB;
   localparam longint DEG360 = 64'sd360 <<< AFB;
   localparam longint unsigned PI_Q32 = 64'h3_243F_6A88;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 6000;

   typedef struct packed {
      logic [15:0] dir_z;
      logic [15:0] dir_y;
      logic [15:0] dir_x;
      logic [15:0] pitch;
      logic [16:0] yaw;
   } view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   // sender and receiver idle percentages
   int     send_idle = 0;
   int     recv_idle = 0;
   int     fail_count = 0;
   int     quiet_cycles = 0;
   view_type expected_views[$];

   // predictor state
   longint unsigned speed;
   bit     first_seen;
   longint prev_x, prev_y, yaw_acc, pitch_acc;

   mouse_look_camera_direction_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned round_shift(longint unsigned v, int s);
      if (s == 0) return v;
      return (v + (64'd1 << (s - 1))) >> s;
   endfunction

   // Taylor sine/cosine magnitudes, Q.30, for an angle in 0..45 degrees
   task automatic taylor(input longint unsigned deg, output longint unsigned sn,
                         output longint unsigned cs);
      longint unsigned x, x2, ts, tc;
      longint s, c;
      x = round_shift((deg * PI_Q32) / 180, AFB + 2);
      x2 = (x * x) >> 30;
      ts = x;
      tc = ONE_Q30;
      s = x;
      c = ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
         tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            s -= ts;
            c -= tc;
         end else begin
            s += ts;
            c += tc;
         end
      end
      sn = (s < 0) ? 0 : s;
      cs = (c < 0) ? 0 : c;
   endtask

   task automatic angle_trig(input longint a, output longint unsigned sm,
                             output bit sneg, output longint unsigned cm,
                             output bit cneg);
      longint quad, r;
      longint unsigned s, c, t;
      quad = a / DEG90;
      r = a % DEG90;
      if (r > DEG45) taylor(DEG90 - r, c, s);
      else taylor(r, s, c);
      sneg = 0;
      cneg = 0;
      case (quad & 3)
         1: begin t = s; s = c; c = t; cneg = 1; end
         2: begin sneg = 1; cneg = 1; end
         3: begin t = s; s = c; c = t; sneg = 1; end
         default: ;
      endcase
      sm = s;
      cm = c;
   endtask

   function automatic logic [15:0] apply_sign(longint unsigned mag, bit neg);
      longint v;
      v = neg ? -longint'(mag) : longint'(mag);
      return v[15:0];
   endfunction

   function automatic longint scale_delta(longint d);
      if (AFB >= 8) return d * (64'sd1 <<< (AFB - 8));
      return d / (64'sd1 <<< (8 - AFB));
   endfunction

   task automatic predict_view(input logic [15:0] xp, input logic [15:0] yp);
      longint x, y, dx, dy, t;
      longint unsigned ys, yc, ps, pc;
      bit ysn, ycn, psn, pcn;
      view_type v;
      x = longint'(signed'(xp));
      y = longint'(signed'(yp));
      if (first_seen) begin
         prev_x = x;
         prev_y = y;
         first_seen = 0;
      end
      dx = x - prev_x;
      dy = prev_y - y;
      prev_x = x;
      prev_y = y;
      t = (yaw_acc + scale_delta(dx * longint'(speed))) % DEG360;
      if (t < 0) t += DEG360;
      yaw_acc = t;
      t = pitch_acc + scale_delta(dy * longint'(speed));
      if (t > DEG89) t = DEG89;
      if (t < -DEG89) t = -DEG89;
      pitch_acc = t;
      angle_trig(yaw_acc, ys, ysn, yc, ycn);
      angle_trig(pitch_acc < 0 ? -pitch_acc : pitch_acc, ps, psn, pc, pcn);
      v.yaw = yaw_acc[16:0];
      v.pitch = pitch_acc[15:0];
      v.dir_x = apply_sign(round_shift(yc * pc, 60 - DFB), ycn);
      v.dir_y = apply_sign(round_shift(ps, 30 - DFB), pitch_acc < 0);
      v.dir_z = apply_sign(round_shift(ys * pc, 60 - DFB), ysn);
      expected_views.push_back(v);
   endtask

   // keep req_tvalid up across back-to-back words; drop it only to idle
   task automatic send_position(input logic [15:0] xp, input logic [15:0] yp);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clock);
      end
      predict_view(xp, yp);
      req_tvalid <= 1'b1;
      req_tdata <= {yp, xp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   // idle the sender until every result is back, then write the speed
   task automatic write_speed(input logic [15:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      speed = value;
   endtask

   // receiver and checker
   always @(posedge clock) begin
      view_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[80:0];
            if (expected_views.size() == 0) begin
               $display("%0t unexpected rsp word %h", $time, got);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               if (got.yaw !== want.yaw || got.pitch !== want.pitch
                   || got.dir_x !== want.dir_x || got.dir_y !== want.dir_y
                   || got.dir_z !== want.dir_z || rsp_tdata[87:81] !== '0) begin
                  $display("%0t mismatch: expected yaw %h pitch %h x %h y %h z %h",
                           $time, want.yaw, want.pitch, want.dir_x, want.dir_y,
                           want.dir_z);
                  $display("%0t           actual yaw %h pitch %h x %h y %h z %h",
                           $time, got.yaw, got.pitch, got.dir_x, got.dir_y,
                           got.dir_z);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_position(16'h1234, 16'h0F00);   // first sample: zero motion
      send_position(16'h1234, 16'h0F00);
      send_position(16'h7FFF, 16'h8000);   // extremes
      send_position(16'h8000, 16'h7FFF);
      send_position(16'hFFFF, 16'h0000);
      send_position(16'h0000, 16'hFFFF);
      send_position(16'h8000, 16'h8000);   // large pitch up, clamp
      send_position(16'h8000, 16'h7FFF);   // large pitch down, clamp
      for (int i = 0; i < 6; i++)          // quarter turns of yaw
         send_position(16'h8000 + 16'(i * 900), 16'h7FFF);
   endtask

   task automatic test_speed_extremes();
      write_speed(16'hFFFF);
      send_position(16'h7FFF, 16'h0000);
      send_position(16'h8000, 16'h0001);
      send_position(16'h0000, 16'hFFFE);
      write_speed(16'h0000);
      send_position(16'h1111, 16'h2222);
      send_position(16'hEEEE, 16'hDDDD);
      write_speed(16'd256);                // one degree per pixel
      for (int i = 0; i < 8; i++) send_position(16'(i * 45), 16'(i * 11));
   endtask

   task automatic test_random(input int count);
      logic [15:0] x, y;
      x = '0;
      y = '0;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0)
            write_speed((i % 240 == 0) ? 16'($urandom) : 16'($urandom_range(512)));
         if (i == count / 2) wait_drained();   // hold until everything is back
         if ($urandom_range(9) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            // small motions, mostly
            x = x + 16'($urandom_range(200)) - 16'd100;
            y = y + 16'($urandom_range(200)) - 16'd100;
         end
         send_position(x, y);
      end
   endtask

   initial begin
      int waited;
      speed = 26;
      first_seen = 1;
      prev_x = 0;
      prev_y = 0;
      yaw_acc = 0;
      pitch_acc = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle = 21;
      recv_idle = 88;
      test_directed();
      test_speed_extremes();
      test_random(240);
      write_speed(16'd26);
      send_idle = 88;
      recv_idle = 21;
      test_random(240);
      send_idle = 0;
      recv_idle = 0;
      test_random(240);
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_views.size() != 0 && waited < 20 * WATCHDOG_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_views.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* mouse_look_camera_direction_core.f */
sv/mlcd_pkg.sv
sv/mlcd_serial_alu.sv
sv/mouse_look_camera_direction_core.sv
sv/mlcd_checker.sv
sim/mouse_look_camera_direction_core_tb.sv
